>>> src/adaptive_lru_live_set_assert.svh
// Assertion macros shared by the checkers of the live-set block.
// Depends on nothing; included by the checker file.
`ifndef ADAPTIVE_LRU_LIVE_SET_ASSERT_SVH
`define ADAPTIVE_LRU_LIVE_SET_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ALLS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ALLS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/alls_pkg.sv
// Package for the adaptive live set: sizes, opcodes, register indexes,
// state and cell command types, and the max_live clamp. No dependencies.
package alls_pkg;

    localparam int MAX_LIVE   = 8;
    localparam int ID_BITS    = 8;
    localparam int CELLS      = MAX_LIVE + 1;
    localparam int IDX_W      = $clog2(CELLS);
    localparam int CNT_W      = $clog2(CELLS + 1);
    localparam int AL_W       = $clog2(MAX_LIVE + 1);
    localparam int MOD_ID_W   = 8;
    localparam int WEIGHT_W   = 41;
    localparam int REG_W      = 40;
    localparam int MAX_LIVE_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = ((MOD_ID_W + WEIGHT_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = MOD_ID_W;

    typedef enum logic [1:0] {
        OP_SHOW    = 2'd0,
        OP_OBSERVE = 2'd1,
        OP_SHED    = 2'd2,
        OP_FORGET  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_LIVE    = 2'd0,
        CFG_CEILING     = 2'd1,
        CFG_RELAX_BELOW = 2'd2
    } cfg_index_t;

    typedef enum logic {
        ST_IDLE,
        ST_TRIM
    } state_t;

    typedef struct packed {
        logic show;
        logic forget;
    } cell_cmd_t;

    function automatic logic [AL_W-1:0] clamp_max_live(input logic [MAX_LIVE_W-1:0] v);
        logic [AL_W-1:0] r;
        if (v == '0) begin
            r = AL_W'(1);
        end else if (int'(v) > MAX_LIVE) begin
            r = AL_W'(MAX_LIVE);
        end else begin
            r = AL_W'(v);
        end
        return r;
    endfunction

endpackage

>>> src/alls_cell.sv
// One slot of the recency chain: holds an id, moves it toward the tail on
// show and toward the head on forget. Depends on alls_pkg.
module alls_cell import alls_pkg::*; (
    input  logic               aclk,
    input  cell_cmd_t          cmd,
    input  logic               valid,
    input  logic [ID_BITS-1:0] id,
    input  logic [ID_BITS-1:0] left_data,
    input  logic [ID_BITS-1:0] right_data,
    input  logic               hit_in,
    output logic [ID_BITS-1:0] data,
    output logic               hit_out
);

    logic [ID_BITS-1:0] data_reg;
    logic [ID_BITS-1:0] data_next;

    assign hit_out = hit_in | (valid && (data_reg == id));
    assign data    = data_reg;

    always_comb begin
        priority if (cmd.show) begin
            // Slots up to the matching one shift back by one place.
            data_next = hit_in ? data_reg : left_data;
        end else if (cmd.forget) begin
            // Slots from the matching one on close the gap.
            data_next = hit_out ? right_data : data_reg;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

>>> src/adaptive_lru_live_set.sv
// Adaptive live set: updates the list on each input beat, then a trim walk that sends
// one eviction beat per cycle while m_tready is high, tail first.
// Forget and observes under the ceiling never enter the trim walk; show, shed and
// over-ceiling observes always enter it, even with nothing to evict; output stalls hold it.
// The first eviction beat is registered after the state register enters ST_TRIM; at most 7 results.
// Reset clears the list (count zero), max_live and allowance to 8, registers to 0.
module adaptive_lru_live_set import alls_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,     // module_id [7:0], weight [48:8], zeros
    input  logic [1:0]           s_tuser,     // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,     // evicted_module [7:0]
    output logic                 m_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_wr_data
);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [AL_W-1:0]      allowance_reg, allowance_next;
    logic [AL_W-1:0]      max_live_reg, max_live_next;
    logic [REG_W-1:0]     ceiling_reg, ceiling_next;
    logic [REG_W-1:0]     relax_reg, relax_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;

    logic                 in_fire;
    opcode_t              op;
    logic [ID_BITS-1:0]   id;
    logic [WEIGHT_W-1:0]  weight;
    cell_cmd_t            cmd;
    logic                 obs_active;
    logic                 over;
    logic                 relax;
    logic                 hit;
    logic                 need_evict;
    logic                 evict_last;
    logic                 out_free;
    logic                 evict_load;
    logic [IDX_W-1:0]     tail_idx;
    logic [AL_W-1:0]      cfg_ml;
    logic [AL_W-1:0]      tight_al;

    logic [ID_BITS-1:0]   cell_data [CELLS];
    logic                 cell_hit  [CELLS];

    assign in_fire = s_tvalid && s_tready;
    assign op      = opcode_t'(s_tuser);
    assign id      = ID_BITS'(s_tdata[MOD_ID_W-1:0]);
    assign weight  = s_tdata[MOD_ID_W +: WEIGHT_W];

    assign cmd.show   = in_fire && (op == OP_SHOW);
    assign cmd.forget = in_fire && (op == OP_FORGET);

    genvar gi;
    generate
        for (gi = 0; gi < CELLS; gi++) begin : g_cell
            logic [ID_BITS-1:0] left_d;
            logic [ID_BITS-1:0] right_d;
            logic               hit_prev;
            if (gi == 0) begin : g_head
                assign left_d   = id;
                assign hit_prev = 1'b0;
            end else begin : g_body
                assign left_d   = cell_data[gi-1];
                assign hit_prev = cell_hit[gi-1];
            end
            if (gi == CELLS - 1) begin : g_tail
                assign right_d = cell_data[gi];
            end else begin : g_inner
                assign right_d = cell_data[gi+1];
            end
            alls_cell u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .valid      (CNT_W'(gi) < count_reg),
                .id         (id),
                .left_data  (left_d),
                .right_data (right_d),
                .hit_in     (hit_prev),
                .data       (cell_data[gi]),
                .hit_out    (cell_hit[gi])
            );
        end
    endgenerate

    assign hit = cell_hit[CELLS-1];

    assign obs_active = (ceiling_reg != '0) && !weight[WEIGHT_W-1];
    assign over       = weight[REG_W-1:0] > ceiling_reg;
    assign relax      = weight[REG_W-1:0] <= relax_reg;

    assign tail_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign need_evict = count_reg > CNT_W'(allowance_reg);
    assign evict_last = (count_reg - CNT_W'(1)) <= CNT_W'(allowance_reg);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign cfg_ml     = clamp_max_live(cfg_wr_data[MAX_LIVE_W-1:0]);

    // Tightened allowance: min(allowance, count - 1), never below one.
    always_comb begin
        if (count_reg <= CNT_W'(1)) begin
            tight_al = AL_W'(1);
        end else if (CNT_W'(allowance_reg) < (count_reg - CNT_W'(1))) begin
            tight_al = allowance_reg;
        end else begin
            tight_al = AL_W'(count_reg - CNT_W'(1));
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && ((op == OP_SHOW) || (op == OP_SHED) ||
                    ((op == OP_OBSERVE) && obs_active && over))) begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM: begin
                if (!need_evict || (out_free && evict_last)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_tready   = 1'b0;
        evict_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready   = 1'b1;
            ST_TRIM: evict_load = need_evict && out_free;
            default: s_tready   = 1'b0;
        endcase
    end

    always_comb begin
        count_next     = count_reg;
        allowance_next = allowance_reg;
        max_live_next  = max_live_reg;
        ceiling_next   = ceiling_reg;
        relax_next     = relax_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MAX_LIVE: begin
                    max_live_next  = cfg_ml;
                    allowance_next = cfg_ml;
                    if (count_reg > CNT_W'(cfg_ml)) begin
                        count_next = CNT_W'(cfg_ml);
                    end
                end
                CFG_CEILING:     ceiling_next = cfg_wr_data;
                CFG_RELAX_BELOW: relax_next   = cfg_wr_data;
                default: begin
                end
            endcase
        end

        if (in_fire) begin
            unique case (op)
                OP_SHOW: begin
                    if (!hit) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_OBSERVE: begin
                    if (obs_active) begin
                        if (over) begin
                            allowance_next = tight_al;
                        end else if (relax) begin
                            allowance_next = max_live_reg;
                        end
                    end
                end
                OP_SHED: allowance_next = AL_W'(1);
                OP_FORGET: begin
                    if (hit) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end else if (evict_load) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (evict_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'(cell_data[tail_idx]);
            m_tlast_next  = evict_last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            allowance_reg <= AL_W'(MAX_LIVE);
            max_live_reg  <= AL_W'(MAX_LIVE);
            ceiling_reg   <= '0;
            relax_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            allowance_reg <= allowance_next;
            max_live_reg  <= max_live_next;
            ceiling_reg   <= ceiling_next;
            relax_reg     <= relax_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> src/alls_checker.sv
// Port-level checker for the adaptive live set, bound to the top level.
// Depends on alls_pkg and adaptive_lru_live_set_assert.svh.
`include "adaptive_lru_live_set_assert.svh"

module alls_checker import alls_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [1:0]           s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // A stalled result beat stays offered.
    `ALLS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")

    // A stalled result beat keeps its payload.
    `ALLS_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "result payload changed while stalled")

    // While a non-final eviction is offered, the trim walk is still running.
    `ALLS_ASSERT_NOW(a_busy_mid_trim, aclk, aresetn, m_tvalid && !m_tlast, !s_tready, "input taken in the middle of a trim")

    // A forget never starts an eviction.
    `ALLS_ASSERT_NEXT(a_forget_quiet, aclk, aresetn, s_tvalid && s_tready && (s_tuser == OP_FORGET) && !m_tvalid, !m_tvalid, "forget produced an eviction")

endmodule

bind adaptive_lru_live_set alls_checker u_alls_checker (.*);
